// File: sv/lgs_pkg.sv
// Shared types, constants and the B3/S23 next-state function for the life stencil.
package lgs_pkg;

  // Configuration port
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_LENGTH = 1'b0,
    CFG_ROW_COUNT  = 1'b1
  } lgs_cfg_e;

  localparam logic [CFG_W-1:0] ROW_LENGTH_RST = 9'd145;
  localparam logic [CFG_W-1:0] ROW_COUNT_RST  = 9'd50;

  // Window geometry: a column is upper (bit 0), center (bit 1), lower (bit 2)
  localparam int unsigned COL_H     = 3;
  localparam int unsigned WIN_CELLS = 2;
  localparam int unsigned WIN_W     = 9;

  localparam logic [WIN_W-1:0] NBR_MASK    = 9'h1EF;
  localparam logic [WIN_W-1:0] LEFT_MASK   = 9'h007;
  localparam logic [WIN_W-1:0] RIGHT_MASK  = 9'h1C0;
  localparam logic [WIN_W-1:0] TOP_MASK    = 9'h049;
  localparam logic [WIN_W-1:0] BOTTOM_MASK = 9'h124;

  // Rule constants
  localparam logic [3:0] BIRTH_CNT   = 4'd3;
  localparam logic [3:0] SURVIVE_CNT = 4'd2;

  typedef struct packed {
    logic alive;
    logic flush;
  } lgs_in_t;

  typedef struct packed {
    logic       next_alive;
    logic [7:0] cell_row;
    logic [7:0] cell_col;
    logic       last;
  } lgs_out_t;

  // Which window edges fall outside the grid
  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bottom;
  } lgs_edge_t;

  // Next state of the center cell from its 3x3 window
  function automatic logic life_rule(logic [WIN_W-1:0] win, lgs_edge_t edg);
    logic [WIN_W-1:0] mask;
    logic [WIN_W-1:0] nbr;
    logic [3:0]       cnt;
    mask = NBR_MASK;
    if (edg.left)   mask = mask & ~LEFT_MASK;
    if (edg.right)  mask = mask & ~RIGHT_MASK;
    if (edg.top)    mask = mask & ~TOP_MASK;
    if (edg.bottom) mask = mask & ~BOTTOM_MASK;
    nbr = win & mask;
    cnt = '0;
    for (int k = 0; k < WIN_W; k++) begin
      cnt = cnt + {3'b000, nbr[k]};
    end
    if (win[4]) begin
      return (cnt == SURVIVE_CNT) || (cnt == BIRTH_CNT);
    end
    return cnt == BIRTH_CNT;
  endfunction

endpackage

// File: sv/lgs_cell.sv
// One column cell of the sliding 3x3 window: holds a 3-cell column, passes it on.
module lgs_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           clr_i,
  input  logic [lgs_pkg::COL_H-1:0]      d_i,
  output logic [lgs_pkg::COL_H-1:0]      q_o
);

  logic [lgs_pkg::COL_H-1:0] col_q, col_d;

  // Row start loads a dead column
  assign col_d = clr_i ? '0 : d_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (en_i) begin
      col_q <= col_d;
    end
  end

  assign q_o = col_q;

endmodule

// File: sv/lgs_line_buf.sv
// Two-row line buffer: one memory word per column {middle, older}, per-column valid bits.
module lgs_line_buf #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [1:0]    wdata_i,
  output logic [1:0]    rdata_o
);

  logic [1:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [1:0]       rd_q;
  logic             rvld_q;
  logic             byp_q;
  logic [1:0]       byp_data_q;

  // Storage write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Never-written columns read as dead
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  // Registered read; a same-cycle write to the read column is forwarded
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q       <= mem[raddr_i];
      rvld_q     <= vld_q[raddr_i];
      byp_q      <= we_i && (waddr_i == raddr_i);
      byp_data_q <= wdata_i;
    end
  end

  assign rdata_o = byp_q ? byp_data_q : (rvld_q ? rd_q : 2'b00);

endmodule

// File: sv/life_generation_stencil.sv
// Top level: raster-order Game of Life (B3/S23) next-generation stencil.
//
// Usage: cells of one generation enter on the in channel (valid/ready), row by row,
// left to right; after the row_count x row_length grid the host sends row_length+1
// flush requests. Each cell's next state leaves on the out channel with its row,
// column and a last flag on the final cell of the generation.
// Throughput: one request per cycle while the output is not stalled. A cell's result
// is computed when the request one row below and one column right of it is accepted,
// and appears on out_valid_o after the line-buffer read register and then the output
// register. The window is a chain of two column cells fed from the line buffer's
// registered read port.
// Configuration: row_length (index 0) and row_count (index 1) through cfg_we_i;
// the user writes them only while the block is idle; the block does not enforce it.
// Reset: stream position goes to row 0, column 0; line-buffer columns read as dead
// until written (per-column valid bits, no clearing pass); output is empty.
// Stall: when out_ready_i is low with a result pending, the whole pipe holds and
// in_ready_o drops; the pending result stays put until taken.
module life_generation_stencil #(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lgs_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lgs_pkg::lgs_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lgs_pkg::lgs_out_t               out_data_o
);

  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned LW = $clog2(MAX_COLS + 1);
  localparam int unsigned RW = $clog2(MAX_ROWS + 3);

  // Configuration registers
  logic [lgs_pkg::CFG_W-1:0] row_length_q, row_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= lgs_pkg::ROW_LENGTH_RST;
      row_count_q  <= lgs_pkg::ROW_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lgs_pkg::CFG_ROW_LENGTH: row_length_q <= cfg_data_i;
        lgs_pkg::CFG_ROW_COUNT:  row_count_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped grid size
  logic [LW-1:0] len;
  logic [RW-1:0] rows, rows_p1;

  always_comb begin
    if (row_length_q == '0) begin
      len = LW'(1);
    end else if (32'(row_length_q) > MAX_COLS) begin
      len = LW'(MAX_COLS);
    end else begin
      len = LW'(row_length_q);
    end
    if (row_count_q == '0) begin
      rows = RW'(1);
    end else if (32'(row_count_q) > MAX_ROWS) begin
      rows = RW'(MAX_ROWS);
    end else begin
      rows = RW'(row_count_q);
    end
    rows_p1 = rows + RW'(1);
  end

  // Handshake and pipeline advance
  logic out_valid_q, out_valid_d;
  logic en, accept;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  // Stream position of the next request
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_n, col_a;
  logic [RW-1:0] row_n, row_a;
  logic [LW-1:0] col_inc;
  logic          a_first, a_alive, a_emit, a_fin;
  logic [RW-1:0] a_cr;
  logic [CW-1:0] a_cc;
  lgs_pkg::lgs_edge_t a_edge;

  always_comb begin
    // Settle a position left stale by a size change
    if (LW'(col_q) >= len) begin
      col_n = '0;
      row_n = row_q + RW'(1);
    end else begin
      col_n = col_q;
      row_n = row_q;
    end
    if ((row_n > rows_p1) || ((row_n == rows_p1) && (col_n != '0))) begin
      col_a = '0;
      row_a = '0;
    end else begin
      col_a = col_n;
      row_a = row_n;
    end

    a_first = (col_a == '0);
    a_alive = in_data_i.alive && !in_data_i.flush && (row_a < rows);
    a_fin   = (row_a == rows_p1) && a_first;
    a_emit  = (row_a >= RW'(2)) || ((row_a == RW'(1)) && !a_first);

    // Center of the evaluated window
    a_cr = a_first ? row_a - RW'(2) : row_a - RW'(1);
    a_cc = a_first ? CW'(len - LW'(1)) : col_a - CW'(1);

    a_edge.left   = (a_cc == '0);
    a_edge.right  = (LW'(a_cc) + LW'(1)) >= len;
    a_edge.top    = (a_cr == '0);
    a_edge.bottom = (a_cr + RW'(1)) >= rows;

    // Advance
    col_inc = LW'(col_a) + LW'(1);
    if (a_fin) begin
      col_d = '0;
      row_d = '0;
    end else if (col_inc >= len) begin
      col_d = '0;
      row_d = row_a + RW'(1);
    end else begin
      col_d = CW'(col_inc);
      row_d = row_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line-buffer read stage
  logic               b_valid_q;
  logic               b_first_q, b_alive_q, b_emit_q, b_fin_q;
  logic [CW-1:0]      b_col_q;
  logic [RW-1:0]      b_cr_q;
  logic [CW-1:0]      b_cc_q;
  lgs_pkg::lgs_edge_t b_edge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_first_q <= a_first;
      b_alive_q <= a_alive;
      b_emit_q  <= a_emit;
      b_fin_q   <= a_fin;
      b_col_q   <= col_a;
      b_cr_q    <= a_cr;
      b_cc_q    <= a_cc;
      b_edge_q  <= a_edge;
    end
  end

  // Rows above: bit 0 older row, bit 1 middle row
  logic [1:0] lb_rd;
  logic       b_fire;

  assign b_fire = en && b_valid_q;

  lgs_line_buf #(
    .DEPTH (MAX_COLS),
    .AW    (CW)
  ) u_line_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .raddr_i (col_a),
    .we_i    (b_fire),
    .waddr_i (b_col_q),
    .wdata_i ({b_alive_q, lb_rd[1]}),
    .rdata_o (lb_rd)
  );

  // Incoming column and the window chain
  logic [lgs_pkg::COL_H-1:0] col_b;
  logic [lgs_pkg::COL_H-1:0] cell_d [lgs_pkg::WIN_CELLS];
  logic [lgs_pkg::COL_H-1:0] cell_q [lgs_pkg::WIN_CELLS];
  logic                      cell_clr [lgs_pkg::WIN_CELLS];

  assign col_b = {b_alive_q, lb_rd[1], lb_rd[0]};

  for (genvar k = 0; k < lgs_pkg::WIN_CELLS; k++) begin : g_win
    if (k == lgs_pkg::WIN_CELLS - 1) begin : g_head
      assign cell_d[k]   = col_b;
      assign cell_clr[k] = 1'b0;
    end else begin : g_tail
      assign cell_d[k]   = cell_q[k+1];
      assign cell_clr[k] = b_first_q;
    end
    lgs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (b_fire),
      .clr_i  (cell_clr[k]),
      .d_i    (cell_d[k]),
      .q_o    (cell_q[k])
    );
  end

  // Evaluate: left and center from the chain, right from the new column
  logic [lgs_pkg::WIN_W-1:0] eval_win;
  logic                      b_res;

  assign eval_win = {(b_first_q ? {lgs_pkg::COL_H{1'b0}} : col_b), cell_q[1], cell_q[0]};
  assign b_res    = lgs_pkg::life_rule(eval_win, b_edge_q);

  // Output register
  lgs_pkg::lgs_out_t out_q;

  assign out_valid_d = b_valid_q && b_emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && out_valid_d) begin
      out_q.next_alive <= b_res;
      out_q.cell_row   <= 8'(b_cr_q);
      out_q.cell_col   <= 8'(b_cc_q);
      out_q.last       <= b_fin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/lgs_checker.sv
// Port-level checks for the life stencil, bound to the top level.
module lgs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input lgs_pkg::lgs_out_t out_data_o
);

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Input is taken whenever the output side can move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("in_ready does not follow output space");

  // A new result needs a request accepted ahead of the read stage and the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching request");

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker (.*);

// File: verif/life_generation_stencil_test.sv
// Self-checking testbench for the raster-order Game of Life next-generation stencil.
`timescale 1ns / 100ps

module life_generation_stencil_test;

  localparam int unsigned GRID_MAX      = 256;
  localparam int unsigned CELL_TARGET   = 1750;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned SETTLE_CYCLES = 6;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_MOSTLY,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic                          clk_i      = 1'b0;
  logic                          rst_ni     = 1'b0;
  logic                          cfg_we_i   = 1'b0;
  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [lgs_pkg::CFG_W-1:0]     cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  lgs_pkg::lgs_in_t              in_data_i  = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  lgs_pkg::lgs_out_t             out_data_o;

  life_generation_stencil uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the stencil: registers, line buffers, window, stream position
  logic [lgs_pkg::CFG_W-1:0] row_len_reg = lgs_pkg::ROW_LENGTH_RST;
  logic [lgs_pkg::CFG_W-1:0] row_cnt_reg = lgs_pkg::ROW_COUNT_RST;
  bit                        older_cells [GRID_MAX];
  bit                        middle_cells[GRID_MAX];
  logic [lgs_pkg::WIN_W-1:0] window_cells = '0;
  int unsigned               stream_col   = 0;
  int unsigned               stream_row   = 0;

  lgs_pkg::lgs_in_t  cell_q[$];      // requests waiting for the driver
  lgs_pkg::lgs_out_t next_gen_q[$];  // predicted next-generation cells, oldest first
  lgs_pkg::lgs_out_t want_cell;
  int unsigned mismatches  = 0;
  int unsigned sent_cells  = 0;
  int unsigned plan_col    = 0;  // where the next queued request lands
  int unsigned plan_row    = 0;

  // Sender burst state
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  // Receiver stall state
  rx_mode_e    rx_mode     = RX_FREE;
  int unsigned mode_left   = 0;
  int unsigned rx_tick     = 0;
  int unsigned hold_left   = 0;
  int unsigned hold_len    = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_taken = 0;
  int unsigned idle_cycles = 0;

  // Register value as the block uses it: 0 acts as 1, above the maximum as the maximum
  function automatic int unsigned effective_size(logic [lgs_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > GRID_MAX) return GRID_MAX;
    return 32'(v);
  endfunction

  // B3/S23 on a window; neighbors beyond the grid edges are ignored
  function automatic logic life_next(logic [lgs_pkg::WIN_W-1:0] view, int unsigned cr,
                                     int unsigned cc, int unsigned len, int unsigned rows);
    int unsigned live;
    live = 0;
    for (int dx = 0; dx < 3; dx++) begin
      for (int dy = 0; dy < 3; dy++) begin
        if (!(dx == 1 && dy == 1) && !(dx == 0 && cc == 0) && !(dx == 2 && cc + 1 >= len) &&
            !(dy == 0 && cr == 0) && !(dy == 2 && cr + 1 >= rows)) begin
          live += 32'(view[3*dx + dy]);
        end
      end
    end
    if (view[4]) return (live == lgs_pkg::SURVIVE_CNT) || (live == lgs_pkg::BIRTH_CNT);
    return live == lgs_pkg::BIRTH_CNT;
  endfunction

  // Advance the shadow by one accepted request and queue the cell it completes
  function automatic void predict_cell(lgs_pkg::lgs_in_t req);
    int unsigned               len, rows, ic, ir, cr, cc;
    logic                      now_alive;
    logic [2:0]                column;
    logic [lgs_pkg::WIN_W-1:0] view;
    bit                        emit, fin;
    lgs_pkg::lgs_out_t         expect_cell;
    len  = effective_size(row_len_reg);
    rows = effective_size(row_cnt_reg);
    // a register change may leave the position out of range
    if (stream_col >= len) begin
      stream_col = 0;
      stream_row++;
    end
    if (stream_row > rows + 1 || (stream_row == rows + 1 && stream_col != 0)) begin
      stream_row = 0;
      stream_col = 0;
    end
    ic = stream_col;
    ir = stream_row;
    // filler rows and flush requests are dead
    now_alive = req.alive && !req.flush && (ir < rows);
    column = {now_alive, middle_cells[ic], older_cells[ic]};
    older_cells[ic]  = middle_cells[ic];
    middle_cells[ic] = now_alive;
    if (ic == 0) begin
      // first column closes the previous row's last cell
      view         = {3'b000, window_cells[lgs_pkg::WIN_W-1:3]};
      window_cells = {column, 6'b000000};
      cr = ir - 2;
      cc = len - 1;
    end else begin
      view         = {column, window_cells[lgs_pkg::WIN_W-1:3]};
      window_cells = view;
      cr = ir - 1;
      cc = ic - 1;
    end
    emit = (ir >= 2) || (ir == 1 && ic >= 1);
    fin  = (ir == rows + 1) && (ic == 0);
    if (fin) begin
      stream_row = 0;
      stream_col = 0;
    end else begin
      stream_col = ic + 1;
      if (stream_col >= len) begin
        stream_col = 0;
        stream_row = ir + 1;
      end
    end
    if (emit) begin
      expect_cell.next_alive = life_next(view, cr, cc, len, rows);
      expect_cell.cell_row   = 8'(cr);
      expect_cell.cell_col   = 8'(cc);
      expect_cell.last       = fin;
      next_gen_q.push_back(expect_cell);
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("check: %s got %0d want %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Sender: bursts of requests separated by random gaps
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (gap_left != 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (cell_q.size() != 0) begin
        in_data_i  <= cell_q.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 48);
          gap_left   <= ($urandom_range(2) == 0) ? $urandom_range(1, 8) : 0;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: predicts on input handshakes, checks output handshakes, drives out_ready_i
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) predict_cell(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (next_gen_q.size() == 0) begin
        report_mismatch("result with nothing pending, row", out_data_o.cell_row, 0);
      end else begin
        want_cell = next_gen_q.pop_front();
        if (out_data_o.next_alive !== want_cell.next_alive)
          report_mismatch("next_alive", out_data_o.next_alive, want_cell.next_alive);
        if (out_data_o.cell_row !== want_cell.cell_row)
          report_mismatch("cell_row", out_data_o.cell_row, want_cell.cell_row);
        if (out_data_o.cell_col !== want_cell.cell_col)
          report_mismatch("cell_col", out_data_o.cell_col, want_cell.cell_col);
        if (out_data_o.last !== want_cell.last)
          report_mismatch("last", out_data_o.last, want_cell.last);
      end
    end
    // long hold-offs first, otherwise one of four randomly chosen stall patterns
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (holds_taken != holds_asked) begin
      holds_taken <= holds_taken + 1;
      hold_left   <= hold_len;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_e'($urandom_range(3));
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      rx_tick <= rx_tick + 1;
      case (rx_mode)
        RX_FREE:   out_ready_i <= 1'b1;
        RX_MOSTLY: out_ready_i <= ($urandom_range(3) != 0);
        RX_SPARSE: out_ready_i <= ($urandom_range(3) == 0);
        default:   out_ready_i <= (rx_tick[2:0] < 3'd5);
      endcase
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(lgs_pkg::lgs_cfg_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= lgs_pkg::CFG_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == lgs_pkg::CFG_ROW_LENGTH) row_len_reg = lgs_pkg::CFG_W'(val);
    else row_cnt_reg = lgs_pkg::CFG_W'(val);
  endtask

  // Wait until every request is in and every cell is out, then let the pipe settle
  task automatic drain();
    while (cell_q.size() != 0 || in_valid_i || next_gen_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    plan_row = stream_row;
    plan_col = stream_col;
  endtask

  // Queue the rest of the current generation from the planned position; cut > 0 stops early
  task automatic queue_generation(int unsigned density, int unsigned noise, int unsigned cut);
    int unsigned      len, rows, pushed;
    lgs_pkg::lgs_in_t c;
    bit               done;
    len    = effective_size(row_len_reg);
    rows   = effective_size(row_cnt_reg);
    pushed = 0;
    done   = 0;
    while (!done) begin
      if (plan_col >= len) begin
        plan_col = 0;
        plan_row++;
      end
      if (plan_row > rows + 1 || (plan_row == rows + 1 && plan_col != 0)) begin
        plan_row = 0;
        plan_col = 0;
      end
      if (plan_row < rows) begin
        c.alive = ($urandom_range(99) < density);
        c.flush = ($urandom_range(99) < noise);
      end else begin
        c.alive = 1'($urandom_range(1));
        c.flush = ($urandom_range(99) >= noise);
      end
      cell_q.push_back(c);
      pushed++;
      sent_cells++;
      if (plan_row == rows + 1) begin
        plan_row = 0;
        plan_col = 0;
        done     = 1;
      end else begin
        plan_col++;
        if (plan_col >= len) begin
          plan_col = 0;
          plan_row++;
        end
      end
      if (cut != 0 && pushed >= cut) done = 1;
    end
  endtask

  // Stimulus
  initial begin
    logic [12:0]      alive_bits;
    logic [12:0]      flush_bits;
    lgs_pkg::lgs_in_t c;
    int unsigned      phase_no, gens, cut, big_cut, len_sel, rows_sel;
    // 3x3 grid: early flush in row 0, live requests in the filler row, final request
    alive_bits = 13'b1011110011111;
    flush_bits = 13'b1101000000010;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(lgs_pkg::CFG_ROW_LENGTH, 3);
    write_reg(lgs_pkg::CFG_ROW_COUNT, 3);
    @(negedge clk_i);
    for (int i = 0; i < 13; i++) begin
      c.alive = alive_bits[i];
      c.flush = flush_bits[i];
      cell_q.push_back(c);
    end
    sent_cells += 13;
    drain();

    // zero sizes act as a 1x1 grid
    write_reg(lgs_pkg::CFG_ROW_LENGTH, 0);
    write_reg(lgs_pkg::CFG_ROW_COUNT, 0);
    @(negedge clk_i);
    queue_generation(100, 0, 0);
    drain();

    // fully live 2x2 block
    write_reg(lgs_pkg::CFG_ROW_LENGTH, 2);
    write_reg(lgs_pkg::CFG_ROW_COUNT, 2);
    @(negedge clk_i);
    queue_generation(100, 0, 0);
    drain();

    // Random phases: mostly small grids, a few at the size limits
    phase_no = 0;
    while (sent_cells < CELL_TARGET) begin
      phase_no++;
      big_cut = 0;
      case (phase_no)
        1: begin len_sel = 511; rows_sel = 1;   end
        3: begin len_sel = 1;   rows_sel = 511; end
        5: begin len_sel = 256; rows_sel = 2;   big_cut = 300; end
        7: begin len_sel = 2;   rows_sel = 256; big_cut = 200; end
        default: begin
          len_sel  = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 12);
          rows_sel = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 10);
        end
      endcase
      // now and then a single register write, which may land mid-generation
      if (phase_no > 8 && $urandom_range(4) == 0) begin
        if ($urandom_range(1)) write_reg(lgs_pkg::CFG_ROW_LENGTH, len_sel);
        else write_reg(lgs_pkg::CFG_ROW_COUNT, rows_sel);
      end else begin
        write_reg(lgs_pkg::CFG_ROW_LENGTH, len_sel);
        write_reg(lgs_pkg::CFG_ROW_COUNT, rows_sel);
      end
      @(negedge clk_i);
      // long receiver hold-off while the sender keeps offering
      if (phase_no == 1 || $urandom_range(7) == 0) begin
        hold_len = (phase_no == 1) ? 400 : $urandom_range(20, 200);
        holds_asked++;
      end
      gens = (big_cut != 0 || phase_no < 8) ? 1 : $urandom_range(1, 3);
      for (int g = 0; g < gens; g++) begin
        cut = (g == gens - 1 && $urandom_range(4) == 0) ? $urandom_range(1, 30) : 0;
        if (big_cut != 0) cut = big_cut;
        queue_generation($urandom_range(10, 60), ($urandom_range(3) == 0) ? 8 : 0, cut);
      end
      drain();
    end

    if (next_gen_q.size() != 0) report_mismatch("cells never produced", 0, next_gen_q.size());
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
